@@ src/tadip_pkg.sv @@
// Shared constants and types for the thread-aware insertion and replacement unit.
package tadip_pkg;

	localparam int NumSets  = 1024;
	localparam int Assoc    = 16;
	localparam int NumApps  = 4;
	localparam int SdmSpan  = 32;
	localparam int PselCap  = 10;

	localparam int SetW     = $clog2(NumSets);
	localparam int WayW     = $clog2(Assoc);
	localparam int AppW     = $clog2(NumApps);
	localparam int StampW   = 32;
	localparam int SelW     = 12;
	localparam int LeadSpan = NumSets / SdmSpan;
	localparam int LeadW    = $clog2(LeadSpan);

	localparam logic [StampW-1:0] LipStamp = '0;

	// Function codes
	localparam logic FUNC_HIT  = 1'b0;
	localparam logic FUNC_MISS = 1'b1;

	// Configuration register indexes
	localparam logic [0:0] REG_BIP_EPSILON = 1'd0;
	localparam logic [0:0] REG_PSEL_BITS   = 1'd1;

	// One accepted request
	typedef struct packed {
		logic              func;
		logic [SetW-1:0]   set_index;
		logic [WayW-1:0]   hit_way;
		logic [AppW-1:0]   app_id;
		logic [StampW-1:0] now_time;
		logic [6:0]        random_pct;
	} req_t;

	// Victim search result
	typedef struct packed {
		logic [WayW-1:0] way;
		logic            was_valid;
	} victim_t;

endpackage

@@ src/thread_aware_insertion_replacement_unit.sv @@
// Flow: the set row is read as the request is taken; in the read state the row is written back
// and the result is registered, then held on m_tdata until the receiver takes it.
// No new request is taken while one is in flight; a pending result holds off the next
// request as well.
// Reset: selectors cleared, registers to defaults, then a valid-bit clearing pass over all
// 1024 set rows (one set row a cycle) during which no request is taken.
module thread_aware_insertion_replacement_unit
	import tadip_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: func, set_index, hit_way, app_id, now_time, random_pct (from bit 0)
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,
	// m_tdata: victim_way, victim_was_valid, inserted_mru, selector_value (from bit 0)
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;

	logic [1:0]            state_q;
	logic [SetW-1:0]       clr_q;
	req_t                  req_q;
	logic [6:0]            eps_q;
	logic [3:0]            psel_q;
	logic signed [SelW-1:0] sel_q [NumApps];
	logic [23:0]           out_q;
	logic                  out_vld_q;

	logic                  mem_we;
	logic [SetW-1:0]       mem_addr;
	logic [Assoc-1:0]      vrow_rd, vrow_wr;
	logic [Assoc*StampW-1:0] srow_rd, srow_wr;
	victim_t               vict;
	req_t                  s_req;

	// Unpack the request fields, func in the lowest bit
	always_comb begin
		s_req.func       = s_tdata[0];
		s_req.set_index  = s_tdata[10:1];
		s_req.hit_way    = s_tdata[14:11];
		s_req.app_id     = s_tdata[16:15];
		s_req.now_time   = s_tdata[48:17];
		s_req.random_pct = s_tdata[55:49];
	end

	assign s_tready  = (state_q == ST_IDLE) && !out_vld_q;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_vld_q;
	assign m_tdata   = out_q;

	tadip_ram #(.Width(Assoc), .Depth(NumSets)) u_valid_ram (
		.clk(clk), .we(mem_we), .addr(mem_addr), .wdata(vrow_wr), .rdata(vrow_rd)
	);

	tadip_ram #(.Width(Assoc*StampW), .Depth(NumSets)) u_stamp_ram (
		.clk(clk), .we(mem_we && state_q == ST_READ), .addr(mem_addr),
		.wdata(srow_wr), .rdata(srow_rd)
	);

	tadip_victim u_victim (.valid_row(vrow_rd), .stamp_row(srow_rd), .victim(vict));

	// Policy and selector update for the request in flight
	logic [LeadW-1:0]       lead_s;
	logic                   lru_lead, bip_lead, bimodal, mru;
	logic [3:0]             pb;
	logic signed [SelW-1:0] lim, cur, nxt;
	logic [WayW-1:0]        way;
	logic                   vv, stamp_mru, wr_way;

	always_comb begin
		lead_s   = req_q.set_index[LeadW-1:0];
		lru_lead = (lead_s == LeadW'({req_q.app_id, 1'b0}));
		bip_lead = (lead_s == LeadW'({req_q.app_id, 1'b1}));
		cur      = sel_q[req_q.app_id];
		bimodal  = bip_lead || (!lru_lead && !cur[SelW-1]);
		mru      = !bimodal || (req_q.random_pct < eps_q);
		pb       = (psel_q > 4'(PselCap)) ? 4'(PselCap) : psel_q;
		lim      = SelW'(1) <<< pb;
		nxt      = cur;
		if (req_q.func == FUNC_MISS && lru_lead) begin
			nxt = (cur + SelW'(1) > lim) ? lim : cur + SelW'(1);
		end else if (req_q.func == FUNC_MISS && bip_lead) begin
			nxt = (cur - SelW'(1) < -lim) ? -lim : cur - SelW'(1);
		end
		if (req_q.func == FUNC_MISS) begin
			way       = vict.way;
			vv        = vict.was_valid;
			stamp_mru = mru;
			wr_way    = 1'b1;
		end else begin
			way       = req_q.hit_way;
			vv        = vrow_rd[req_q.hit_way];
			stamp_mru = 1'b1;
			wr_way    = 1'b1;
		end
		vrow_wr = vrow_rd;
		srow_wr = srow_rd;
		if (state_q == ST_READ && wr_way) begin
			if (req_q.func == FUNC_MISS) begin
				vrow_wr[way] = 1'b1;
			end
			srow_wr[way*StampW +: StampW] = stamp_mru ? req_q.now_time : LipStamp;
		end
		if (state_q == ST_CLEAR) begin
			vrow_wr = '0;
		end
	end

	assign mem_we   = (state_q == ST_CLEAR) || (state_q == ST_READ);
	assign mem_addr = (state_q == ST_CLEAR) ? clr_q :
	                  (state_q == ST_IDLE) ? s_req.set_index : req_q.set_index;

	// Request and result capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q <= s_req;
		end
		if (state_q == ST_READ) begin
			out_q <= {6'b0, nxt, stamp_mru, vv, way};
		end
	end

	// Control, configuration and selectors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			out_vld_q <= 1'b0;
			eps_q     <= 7'd3;
			psel_q    <= 4'd10;
			for (int a = 0; a < NumApps; a++) begin
				sel_q[a] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_BIP_EPSILON: eps_q  <= cfg_data;
					REG_PSEL_BITS:   psel_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SetW'(1);
					if (clr_q == SetW'(NumSets - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					sel_q[req_q.app_id] <= nxt;
					out_vld_q           <= 1'b1;
					state_q             <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ src/tadip_ram.sv @@
// Generic single-port synchronous RAM with registered read.
module tadip_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ src/tadip_victim.sv @@
// Victim search over one set row: first invalid way, else smallest stamp.
module tadip_victim
	import tadip_pkg::*;
(
	input  logic [Assoc-1:0]         valid_row,
	input  logic [Assoc*StampW-1:0]  stamp_row,
	output victim_t                  victim
);

	logic [WayW-1:0]   inv_way;
	logic              inv_found;
	logic [WayW-1:0]   lvl_way  [2*Assoc-1];
	logic [StampW-1:0] lvl_stmp [2*Assoc-1];

	// Priority search for the first invalid way
	always_comb begin
		inv_way   = '0;
		inv_found = 1'b0;
		for (int w = Assoc - 1; w >= 0; w--) begin
			if (!valid_row[w]) begin
				inv_way   = WayW'(w);
				inv_found = 1'b1;
			end
		end
	end

	// Minimum tree, lower way wins ties
	always_comb begin
		for (int w = 0; w < Assoc; w++) begin
			lvl_way[Assoc-1+w]  = WayW'(w);
			lvl_stmp[Assoc-1+w] = stamp_row[w*StampW +: StampW];
		end
		for (int n = Assoc - 2; n >= 0; n--) begin
			if (lvl_stmp[2*n+2] < lvl_stmp[2*n+1]) begin
				lvl_way[n]  = lvl_way[2*n+2];
				lvl_stmp[n] = lvl_stmp[2*n+2];
			end else begin
				lvl_way[n]  = lvl_way[2*n+1];
				lvl_stmp[n] = lvl_stmp[2*n+1];
			end
		end
	end

	assign victim.way       = inv_found ? inv_way : lvl_way[0];
	assign victim.was_valid = !inv_found;

endmodule

@@ src/tadip_checker.sv @@
// Port-level checker for the insertion and replacement unit, bound to the top level.
module tadip_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// Result stays put while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A request is never taken back to back
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken in consecutive cycles");

	// Every request yields a result, registered in the read state
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> ##1 m_tvalid)
		else $error("missing result");

	// No request taken while a result waits
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("request taken while result pending");

	// Selector (a 12-bit field) stays within its saturation range of -1024 to 1024
	a_sel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[17:6]) <= 12'sd1024 &&
		              $signed(m_tdata[17:6]) >= -12'sd1024))
		else $error("selector out of range");

endmodule

bind thread_aware_insertion_replacement_unit tadip_checker u_tadip_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
